// File: hdl/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared constants, types and the arctangent table for the bearing and
// distance pipeline.
// ----------------------------------------------------------------------------
package bdp_pkg;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_COORD_BITS   = 16;

	localparam int GUARD_BITS   = 8;
	localparam int TABLE_LEN    = 24;
	localparam int ANGLE_BITS   = 32;
	localparam int BEARING_BITS = 15;
	localparam int DIST_BITS    = 17;

	// angles in units of 2^-22 degree
	localparam logic signed [ANGLE_BITS-1:0] DEG180 = 32'sd754974720;
	localparam int BEARING_FULL = 23040;
	localparam int DIST_MAX     = 131071;

	// 1/K = 2608131496 / 2^32 split into 16-bit halves
	localparam int INVK_HI = 39796;
	localparam int INVK_LO = 60840;

	typedef struct packed {
		logic valid;
		logic zero;
	} tag_t;

	function automatic logic signed [ANGLE_BITS-1:0] atan_tab(input int i);
		logic signed [ANGLE_BITS-1:0] v;
		case (i)
			0:       v = 32'sd188743680;
			1:       v = 32'sd111421900;
			2:       v = 32'sd58872272;
			3:       v = 32'sd29884485;
			4:       v = 32'sd15000234;
			5:       v = 32'sd7507429;
			6:       v = 32'sd3754631;
			7:       v = 32'sd1877430;
			8:       v = 32'sd938729;
			9:       v = 32'sd469366;
			10:      v = 32'sd234683;
			11:      v = 32'sd117342;
			12:      v = 32'sd58671;
			13:      v = 32'sd29335;
			14:      v = 32'sd14668;
			15:      v = 32'sd7334;
			16:      v = 32'sd3667;
			17:      v = 32'sd1833;
			18:      v = 32'sd917;
			19:      v = 32'sd458;
			20:      v = 32'sd229;
			21:      v = 32'sd115;
			22:      v = 32'sd57;
			23:      v = 32'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/bearing_and_distance_between_points.sv
// ----------------------------------------------------------------------------
// bearing_and_distance_between_points
// Bearing (1/64 degree, 0..359.98) and rounded Euclidean distance from an
// origin point to a target point, via a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// Takes one point pair per cycle unless the output stalls, and returns one
// result per pair, in order. Stages: a difference stage, a half-plane fold
// stage, one register stage per micro-rotation, a stage for bearing rounding
// and the 1/K partial products, and the output register that sums and rounds
// the distance. Every stage has its own valid bit and advances when it is
// empty or its successor advances, so bubbles are squeezed out and the input
// keeps taking transfers while a result waits at the output until all are full.
module bearing_and_distance_between_points #(
	parameter int CORDIC_STEPS = bdp_pkg::DEF_CORDIC_STEPS,
	parameter int COORD_BITS   = bdp_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// origin_x, origin_y, target_x, target_y, zero fill to bytes
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// bearing [14:0], distance [31:15]
	output logic [bdp_pkg::BEARING_BITS+bdp_pkg::DIST_BITS-1:0] m_axis_tdata
);
	import bdp_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int W      = COORD_BITS + GUARD_BITS + 3;
	localparam int STAGES = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int SW     = W + 17;
	localparam int DW     = W - 7;

	logic signed [C-1:0] origin_x, origin_y, target_x, target_y;

	assign origin_x = $signed(s_axis_tdata[C-1:0]);
	assign origin_y = $signed(s_axis_tdata[2*C-1:C]);
	assign target_x = $signed(s_axis_tdata[3*C-1:2*C]);
	assign target_y = $signed(s_axis_tdata[4*C-1:3*C]);

	// difference
	logic              valid_s1, zero_s1, take_s1;
	logic signed [C:0] dx_s1, dy_s1, dx_c, dy_c;
	logic              take_s2;

	assign dx_c    = (C+1)'(target_x) - (C+1)'(origin_x);
	assign dy_c    = (C+1)'(target_y) - (C+1)'(origin_y);
	assign take_s1 = !valid_s1 || take_s2;
	assign s_axis_tready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && s_axis_tvalid) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			zero_s1 <= (dx_c == '0) && (dy_c == '0);
		end
	end

	// fold the left half-plane, scale up by the guard bits
	logic                         valid_s2, zero_s2;
	logic signed [W-1:0]          x_s2, y_s2, dxe, dye, x0, y0;
	logic signed [ANGLE_BITS-1:0] z_s2;
	logic                         neg;

	logic signed [W-1:0]          cx [STAGES+1];
	logic signed [W-1:0]          cy [STAGES+1];
	logic signed [ANGLE_BITS-1:0] cz [STAGES+1];
	tag_t                         ctag [STAGES+1];
	logic                         cready [STAGES+1];

	assign take_s2 = !valid_s2 || cready[0];
	assign neg     = dx_s1[C];
	assign dxe     = W'(dx_s1);
	assign dye     = W'(dy_s1);
	assign x0      = (neg ? -dxe : dxe) <<< GUARD_BITS;
	assign y0      = (neg ? -dye : dye) <<< GUARD_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && valid_s1) begin
			x_s2    <= x0;
			y_s2    <= y0;
			z_s2    <= neg ? DEG180 : '0;
			zero_s2 <= zero_s1;
		end
	end

	assign cx[0]         = x_s2;
	assign cy[0]         = y_s2;
	assign cz[0]         = z_s2;
	assign ctag[0].valid = valid_s2;
	assign ctag[0].zero  = zero_s2;

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		bdp_cordic_stage #(
			.W    (W),
			.STEP (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.tag     (ctag[i]),
			.x       (cx[i]),
			.y       (cy[i]),
			.z       (cz[i]),
			.take    (cready[i]),
			.tag_rot (ctag[i+1]),
			.x_rot   (cx[i+1]),
			.y_rot   (cy[i+1]),
			.z_rot   (cz[i+1]),
			.drain   (cready[i+1])
		);
	end

	// bearing rounding and wrap, 1/K partial products
	logic                           valid_s3, zero_s3, take_s3, take_s4;
	logic [BEARING_BITS-1:0]        bearing_s3, bearing_c;
	logic [W+14:0]                  phi_s3, phi_c, plo_c;
	logic [W-2:0]                   plo_s3, ux;
	logic signed [ANGLE_BITS-1:0]   zr;
	logic signed [16:0]             rw, rv;
	logic signed [W-1:0]            xf;
	logic signed [ANGLE_BITS-1:0]   zf;

	assign xf        = cx[STAGES];
	assign zf        = cz[STAGES];
	assign take_s3   = !valid_s3 || take_s4;
	assign cready[STAGES] = take_s3;

	always_comb begin
		zr = zf + ANGLE_BITS'(32'sd32768);
		rw = 17'($signed(zr[ANGLE_BITS-1:16]));
		if (rw < 0) begin
			rw = rw + 17'(BEARING_FULL);
		end
		rv = rw;
		if (rv >= 17'(BEARING_FULL)) begin
			rv = rv - 17'(BEARING_FULL);
		end
		bearing_c = ctag[STAGES].zero ? '0 : rv[BEARING_BITS-1:0];
		ux        = xf[W-1] ? '0 : xf[W-2:0];
		phi_c     = (W+15)'(ux) * (W+15)'(INVK_HI);
		plo_c     = (W+15)'(ux) * (W+15)'(INVK_LO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take_s3) begin
			valid_s3 <= ctag[STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && ctag[STAGES].valid) begin
			bearing_s3 <= bearing_c;
			zero_s3    <= ctag[STAGES].zero;
			phi_s3     <= phi_c;
			plo_s3     <= plo_c[W+14:16];
		end
	end

	// distance sum, round half up, saturate
	logic                    valid_s4;
	logic [BEARING_BITS-1:0] bearing_s4;
	logic [DIST_BITS-1:0]    dist_s4, dist_c;
	logic [SW-1:0]           sum;
	logic [DW+16:0]          dist_ext;

	assign take_s4 = !valid_s4 || m_axis_tready;

	always_comb begin
		sum      = SW'(phi_s3) + SW'(plo_s3) + (SW'(1) << (15 + GUARD_BITS));
		dist_ext = (DW+17)'(sum[SW-1:24]);
		if (zero_s3) begin
			dist_c = '0;
		end else if (dist_ext > (DW+17)'(DIST_MAX)) begin
			dist_c = DIST_BITS'(DIST_MAX);
		end else begin
			dist_c = dist_ext[DIST_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (take_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4 && valid_s3) begin
			bearing_s4 <= bearing_s3;
			dist_s4    <= dist_c;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {dist_s4, bearing_s4};

endmodule

// File: hdl/bdp_cordic_stage.sv
// ----------------------------------------------------------------------------
// bdp_cordic_stage
// One registered vectoring micro-rotation with its own valid and stall
// handling.
// ----------------------------------------------------------------------------
module bdp_cordic_stage #(
	parameter int W    = 27,
	parameter int STEP = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bdp_pkg::tag_t                          tag,
	input  logic signed [W-1:0]                    x,
	input  logic signed [W-1:0]                    y,
	input  logic signed [bdp_pkg::ANGLE_BITS-1:0]  z,
	output logic                                   take,
	output bdp_pkg::tag_t                          tag_rot,
	output logic signed [W-1:0]                    x_rot,
	output logic signed [W-1:0]                    y_rot,
	output logic signed [bdp_pkg::ANGLE_BITS-1:0]  z_rot,
	input  logic                                   drain
);
	import bdp_pkg::*;

	localparam logic signed [ANGLE_BITS-1:0] ATAN = atan_tab(STEP);

	logic signed [W-1:0]          xs, ys, x_nx, y_nx;
	logic signed [ANGLE_BITS-1:0] z_nx;
	logic                         valid_s1, zero_s1;
	logic signed [W-1:0]          x_s1, y_s1;
	logic signed [ANGLE_BITS-1:0] z_s1;

	assign take = !valid_s1 || drain;

	always_comb begin
		xs = x >>> STEP;
		ys = y >>> STEP;
		if (!y[W-1]) begin
			x_nx = x + ys;
			y_nx = y - xs;
			z_nx = z + ATAN;
		end else begin
			x_nx = x - ys;
			y_nx = y + xs;
			z_nx = z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && tag.valid) begin
			zero_s1 <= tag.zero;
			x_s1    <= x_nx;
			y_s1    <= y_nx;
			z_s1    <= z_nx;
		end
	end

	assign tag_rot.valid = valid_s1;
	assign tag_rot.zero  = zero_s1;
	assign x_rot         = x_s1;
	assign y_rot         = y_s1;
	assign z_rot         = z_s1;

endmodule
